[rtl/serial_packet_deframer_crc8_defines.svh]
// Assertion macros used by the checker file spdc_checker.sv.
`ifndef SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define SPDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spdc check failed");

// Check a consequent in the cycle after its antecedent.
`define SPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spdc check failed");

`endif

[rtl/spdc_pkg.sv]
`timescale 1ns / 1ps
package spdc_pkg;

   localparam int unsigned SYNC_LEN  = 12;
   localparam int unsigned OUT_LEN_W = 16;
   localparam logic [7:0]  CRC_POLY  = 8'h07;
   localparam logic [7:0]  CRC_INIT  = 8'h00;

   typedef enum logic [1:0] {
      PH_RESYNC  = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_SYNC   = 3'd1,
      EV_HEADER = 3'd2,
      EV_BYTE   = 3'd3,
      EV_GOOD   = 3'd4,
      EV_BAD    = 3'd5,
      EV_ERROR  = 3'd6
   } event_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_error;
   } req_type;

   typedef struct packed {
      event_type             event_res;
      logic [7:0]            data_byte;
      logic [7:0]            packet_type;
      logic [OUT_LEN_W-1:0]  packet_length;
      logic [OUT_LEN_W-1:0]  byte_index;
      logic                  last_payload;
   } rsp_type;

   // Expected byte at each position of the sync sequence.
   function automatic logic [7:0] sync_byte(input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'haa;
         4'd1:    b = 8'h08;
         4'd2:    b = 8'h00;
         4'd3,
         4'd4,
         4'd5,
         4'd6,
         4'd7,
         4'd8:    b = 8'hff;
         4'd9:    b = 8'h12;
         4'd10:   b = 8'hab;
         4'd11:   b = 8'hd6;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Byte-wide CRC-8 update, MSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[rtl/spdc_skid.sv]
`timescale 1ns / 1ps
module spdc_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  spdc_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output spdc_pkg::rsp_type out_data
);
   import spdc_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    out_take;

   // Stall is registered: only a full skid stage holds off the writer.
   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign out_take  = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || out_take) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

[rtl/serial_packet_deframer_crc8.sv]
`timescale 1ns / 1ps
// Serial packet deframer with CRC-8 check (poly 0x07, init 0).
// Request channel (req_valid / req_stall / req_data): one received byte, or a
// line error, per word. Response channel (rsp_valid / rsp_stall / rsp_data):
// exactly one result word per request word, in order.
// After reset the block hunts for the 12-byte sync sequence, then parses
// frames: type byte, 16-bit little-endian length, payload, CRC-8 byte.
// Payload bytes stream out with their index and a last mark; a bad CRC or a
// line error sends the block back to resync and the receiver must drop the
// payload it already took for that frame.
// Each result word is registered into the result register, or the skid stage
// when that is held. Throughput: one word per cycle while req_stall is low;
// the whole parse step and the unrolled byte-wide CRC update sit between the
// frame state and the result register.
// Stall: a two-entry output (result register plus skid stage) keeps taking
// words while the receiver stalls; req_stall rises once both entries hold
// words and is driven from a register.
// Reset (synchronous, active high): empty both output entries, return to
// resync with all counts, type, length and CRC cleared.
module serial_packet_deframer_crc8 #(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spdc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spdc_pkg::rsp_type rsp_data
);
   import spdc_pkg::*;

   // Frame state.
   phase_type            phase_ff, phase_in;
   logic [3:0]           sync_match_count_ff, sync_match_count_in;
   logic [1:0]           header_count_ff, header_count_in;
   logic [7:0]           frame_type_ff, frame_type_in;
   logic [LEN_WIDTH-1:0] frame_length_ff, frame_length_in;
   logic [LEN_WIDTH-1:0] bytes_remaining_ff, bytes_remaining_in;
   logic [7:0]           crc_accum_ff, crc_accum_in;
   logic [7:0]           len_low_ff, len_low_in;

   logic                 req_accept;
   logic [7:0]           rx;
   logic [3:0]           sync_count_inc;
   logic [15:0]          hdr_len;
   logic [LEN_WIDTH-1:0] remaining_dec;
   rsp_type              result;

   assign req_accept     = req_valid && !req_stall;
   assign rx             = req_data.rx_byte;
   assign sync_count_inc = sync_match_count_ff + 4'd1;
   assign hdr_len        = {rx, len_low_ff};
   assign remaining_dec  = bytes_remaining_ff - LEN_WIDTH'(1);

   // Next state and result word for the accepted byte.
   always_comb begin
      phase_in            = phase_ff;
      sync_match_count_in = sync_match_count_ff;
      header_count_in     = header_count_ff;
      frame_type_in       = frame_type_ff;
      frame_length_in     = frame_length_ff;
      bytes_remaining_in  = bytes_remaining_ff;
      crc_accum_in        = crc_accum_ff;
      len_low_in          = len_low_ff;
      result              = '0;
      result.event_res    = EV_NONE;

      if (req_accept) begin
         if (req_data.line_error) begin
            // Abort from any phase; keep type and length.
            phase_in            = PH_RESYNC;
            sync_match_count_in = 4'd0;
            result.event_res    = EV_ERROR;
         end else begin
            case (phase_ff)
               PH_RESYNC: begin
                  // Naive match: a mismatch restarts the count, no recheck.
                  if (rx == sync_byte(sync_match_count_ff)) begin
                     if (32'(sync_count_inc) >= SYNC_LEN) begin
                        sync_match_count_in = 4'd0;
                        header_count_in     = 2'd0;
                        phase_in            = PH_HEADER;
                        result.event_res    = EV_SYNC;
                     end else begin
                        sync_match_count_in = sync_count_inc;
                     end
                  end else begin
                     sync_match_count_in = 4'd0;
                  end
               end
               PH_HEADER: begin
                  case (header_count_ff)
                     2'd0: begin
                        frame_type_in   = rx;
                        header_count_in = 2'd1;
                     end
                     2'd1: begin
                        len_low_in      = rx;
                        header_count_in = 2'd2;
                     end
                     default: begin
                        frame_length_in    = hdr_len[LEN_WIDTH-1:0];
                        bytes_remaining_in = hdr_len[LEN_WIDTH-1:0];
                        crc_accum_in       = CRC_INIT;
                        header_count_in    = 2'd0;
                        // Skip straight to the checksum on an empty payload.
                        phase_in = (hdr_len[LEN_WIDTH-1:0] == '0) ? PH_CHECK : PH_PAYLOAD;
                        result.event_res   = EV_HEADER;
                     end
                  endcase
               end
               PH_PAYLOAD: begin
                  crc_accum_in       = crc8_update(crc_accum_ff, rx);
                  bytes_remaining_in = remaining_dec;
                  result.event_res   = EV_BYTE;
                  result.data_byte   = rx;
                  result.byte_index  = OUT_LEN_W'(frame_length_ff - bytes_remaining_ff);
                  if (remaining_dec == '0) begin
                     result.last_payload = 1'b1;
                     phase_in            = PH_CHECK;
                  end
               end
               default: begin
                  if (rx == crc_accum_ff) begin
                     result.event_res = EV_GOOD;
                     header_count_in  = 2'd0;
                     phase_in         = PH_HEADER;
                  end else begin
                     result.event_res    = EV_BAD;
                     sync_match_count_in = 4'd0;
                     phase_in            = PH_RESYNC;
                  end
               end
            endcase
         end
      end

      // Report type and length as they stand after this word.
      result.packet_type   = frame_type_in;
      result.packet_length = OUT_LEN_W'(frame_length_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_RESYNC;
         sync_match_count_ff <= 4'd0;
         header_count_ff     <= 2'd0;
         frame_type_ff       <= 8'd0;
         frame_length_ff     <= '0;
         bytes_remaining_ff  <= '0;
         crc_accum_ff        <= CRC_INIT;
         len_low_ff          <= 8'd0;
      end else begin
         phase_ff            <= phase_in;
         sync_match_count_ff <= sync_match_count_in;
         header_count_ff     <= header_count_in;
         frame_type_ff       <= frame_type_in;
         frame_length_ff     <= frame_length_in;
         bytes_remaining_ff  <= bytes_remaining_in;
         crc_accum_ff        <= crc_accum_in;
         len_low_ff          <= len_low_in;
      end
   end

   // Result register plus skid stage toward the receiver.
   spdc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

[rtl/spdc_checker.sv]
`timescale 1ns / 1ps
`include "serial_packet_deframer_crc8_defines.svh"
module spdc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input spdc_pkg::rsp_type rsp_data
);
   import spdc_pkg::*;

   // Hold a stalled result word.
   `SPDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Leave payload fields clear on every other event.
   `SPDC_ASSERT_NOW(a_non_byte_clear, clock, reset, rsp_valid && rsp_data.event_res != EV_BYTE, rsp_data.data_byte == 8'd0 && rsp_data.byte_index == 16'd0 && !rsp_data.last_payload)

   // Keep payload index inside the header length.
   `SPDC_ASSERT_NOW(a_index_range, clock, reset, rsp_valid && rsp_data.event_res == EV_BYTE, rsp_data.byte_index < rsp_data.packet_length)

   // Mark last on the final index only.
   `SPDC_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_data.last_payload, rsp_data.byte_index == rsp_data.packet_length - 16'd1)

endmodule

bind serial_packet_deframer_crc8 spdc_checker u_spdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
